@@ rtl/neva_pkg.sv @@
// Package for the nearest earlier value search block.
// Holds the shared widths, the default store depth and the token control struct.
// No dependencies.
`timescale 1ns / 1ps

package neva_pkg;

	// Default number of values kept per sequence.
	localparam int NEVA_DEPTH = 1024;

	// Fixed field widths of the stream words.
	localparam int VALUE_W     = 32;
	localparam int INDEX_OUT_W = 11;

	// Control bits that travel with a query token along the cell row.
	typedef struct packed {
		logic valid;
		logic found;
	} neva_ctl_t;

endpackage : neva_pkg

@@ rtl/nearest_earlier_value_search.sv @@
// Each accepted input word passes the row of DEPTH cell registers and then the output register.
// Throughput: one word per cycle while the row is not stalled; each query walks the row of DEPTH
// comparator cells, one cell per cycle, and a new query may enter behind it in the next cycle.
// The whole row stalls while a finished result waits to be taken.
// Reset clears the fill count and all token valid bits; stored values need no clearing.
`timescale 1ns / 1ps

// Top level of the nearest earlier value search.
// Depends on neva_pkg and neva_cell.
module nearest_earlier_value_search import neva_pkg::*; #(
	parameter int DEPTH = NEVA_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic        s_axis_tuser,  // [0] start_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [31:0] distance, [42:32] nearest_index, zero above
	output logic        m_axis_tuser   // [0] overflow
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

	logic               en;
	logic               accept;
	logic [CNT_W-1:0]   item_count_q;
	logic [CNT_W-1:0]   entry_count;

	neva_ctl_t          ctl_c    [DEPTH+1];
	logic [VALUE_W-1:0] value_c  [DEPTH+1];
	logic [CNT_W-1:0]   count_c  [DEPTH+1];
	logic [VALUE_W-1:0] best_d_c [DEPTH+1];
	logic [VALUE_W-1:0] best_v_c [DEPTH+1];
	logic [POS_W-1:0]   best_i_c [DEPTH+1];

	logic               last_result;
	logic [POS_W:0]     pos_one;
	logic               out_valid_q;
	logic [VALUE_W-1:0] distance_q;
	logic [INDEX_OUT_W-1:0] nearest_index_q;
	logic               overflow_q;

	// The row advances whenever the output register is free or being emptied.
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// A start request restarts the fill count before this word is placed.
	assign entry_count = s_axis_tuser ? '0 : item_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
		end else if (accept) begin
			if (entry_count != FULL_C) begin
				item_count_q <= entry_count + ONE_C;
			end
		end
	end

	// Entry of a new query token into the first cell.
	assign ctl_c[0].valid = s_axis_tvalid;
	assign ctl_c[0].found = 1'b0;
	assign value_c[0]     = s_axis_tdata;
	assign count_c[0]     = entry_count;
	assign best_d_c[0]    = '0;
	assign best_v_c[0]    = '0;
	assign best_i_c[0]    = '0;

	// The row of comparator cells.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		neva_cell #(
			.DEPTH (DEPTH),
			.IDX   (k),
			.CNT_W (CNT_W),
			.POS_W (POS_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.ctl_in     (ctl_c[k]),
			.value_in   (value_c[k]),
			.count_in   (count_c[k]),
			.best_d_in  (best_d_c[k]),
			.best_v_in  (best_v_c[k]),
			.best_i_in  (best_i_c[k]),
			.ctl_out    (ctl_c[k+1]),
			.value_out  (value_c[k+1]),
			.count_out  (count_c[k+1]),
			.best_d_out (best_d_c[k+1]),
			.best_v_out (best_v_c[k+1]),
			.best_i_out (best_i_c[k+1])
		);
	end

	// A first word of a sequence leaves the row without a result.
	assign last_result = ctl_c[DEPTH].valid && (count_c[DEPTH] != '0);
	assign pos_one     = {1'b0, best_i_c[DEPTH]} + {{POS_W{1'b0}}, 1'b1};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last_result;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_q      <= best_d_c[DEPTH];
			nearest_index_q <= INDEX_OUT_W'(pos_one);
			overflow_q      <= (count_c[DEPTH] == FULL_C);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, nearest_index_q, distance_q};
	assign m_axis_tuser  = overflow_q;

`ifndef NO_ASSERTIONS
	// The fill count never runs past the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_count_q <= FULL_C)
		else $error("fill count beyond store depth");

	// An accepted start request leaves exactly one value in the store.
	a_start_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser) |=> (item_count_q == ONE_C))
		else $error("start request did not restart the fill count");

	// A first word reaching the row end produces no result word.
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl_c[DEPTH].valid && (count_c[DEPTH] == '0)) |=> !m_axis_tvalid)
		else $error("result word produced for a first word");

	// Every token leaving the row with earlier values has found a candidate.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |-> ctl_c[DEPTH].found)
		else $error("query left the row without a candidate");
`endif

endmodule : nearest_earlier_value_search

@@ rtl/neva_cell.sv @@
// One cell of the comparator row: holds one stored value of the sequence.
// Depends on neva_pkg for widths and the token control struct.
`timescale 1ns / 1ps

module neva_cell import neva_pkg::*; #(
	parameter int DEPTH = NEVA_DEPTH,
	parameter int IDX   = 0,
	parameter int CNT_W = $clog2(DEPTH + 1),
	parameter int POS_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  neva_ctl_t          ctl_in,
	input  logic [VALUE_W-1:0] value_in,
	input  logic [CNT_W-1:0]   count_in,
	input  logic [VALUE_W-1:0] best_d_in,
	input  logic [VALUE_W-1:0] best_v_in,
	input  logic [POS_W-1:0]   best_i_in,
	output neva_ctl_t          ctl_out,
	output logic [VALUE_W-1:0] value_out,
	output logic [CNT_W-1:0]   count_out,
	output logic [VALUE_W-1:0] best_d_out,
	output logic [VALUE_W-1:0] best_v_out,
	output logic [POS_W-1:0]   best_i_out
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [POS_W-1:0] POS_C = POS_W'(IDX);

	logic [VALUE_W-1:0] stored_q;
	logic [VALUE_W-1:0] diff;
	logic               live;
	logic               better;
	logic               take;
	logic               store;
	neva_ctl_t          ctl_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   count_q;
	logic [VALUE_W-1:0] best_d_q;
	logic [VALUE_W-1:0] best_v_q;
	logic [POS_W-1:0]   best_i_q;

	// Compare the passing query with this cell's value.
	always_comb begin
		if ($signed(value_in) < $signed(stored_q)) begin
			diff = stored_q - value_in;
		end else begin
			diff = value_in - stored_q;
		end
		live   = ctl_in.valid && (count_in > IDX_C);
		better = (diff < best_d_in) ||
			((diff == best_d_in) && ($signed(stored_q) < $signed(best_v_in)));
		take   = live && (!ctl_in.found || better);
		store  = ctl_in.valid && (count_in == IDX_C);
	end

	// The query whose fill count points here leaves its value behind.
	always_ff @(posedge clk) begin
		if (en && store) begin
			stored_q <= value_in;
		end
	end

	// Token control moves one cell per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q.valid <= ctl_in.valid;
			ctl_q.found <= ctl_in.found || take;
		end
	end

	// Token payload with the best candidate found so far.
	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= value_in;
			count_q  <= count_in;
			best_d_q <= take ? diff : best_d_in;
			best_v_q <= take ? stored_q : best_v_in;
			best_i_q <= take ? POS_C : best_i_in;
		end
	end

	assign ctl_out    = ctl_q;
	assign value_out  = value_q;
	assign count_out  = count_q;
	assign best_d_out = best_d_q;
	assign best_v_out = best_v_q;
	assign best_i_out = best_i_q;

endmodule : neva_cell

@@ tb/nearest_earlier_value_search_tb.sv @@
// Self-checking testbench for the nearest earlier value search block.
// It predicts each result word from its own model of the value store and checks every word.
// Depends on neva_pkg and nearest_earlier_value_search.
`timescale 1ns / 1ps

module nearest_earlier_value_search_tb import neva_pkg::*;;

	localparam int STORE_DEPTH = NEVA_DEPTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 2500;
	localparam int SETTLE      = STORE_DEPTH + 16;
	localparam int MAX_REPORTS = 100;

	localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

	// How the values of one random sequence are spread.
	typedef enum int {
		SPREAD_FULL,
		SPREAD_NEAR,
		SPREAD_EDGE,
		SPREAD_TINY
	} spread_t;

	// One expected result word.
	typedef struct packed {
		logic [VALUE_W-1:0]     distance;
		logic [INDEX_OUT_W-1:0] nearest_index;
		logic                   overflow;
	} nearest_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [31:0] value
	logic        s_axis_tuser;  // [0] start_req
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // [31:0] distance, [42:32] nearest_index, zero above
	logic        m_axis_tuser;  // [0] overflow

	// Own copy of the sequence store.
	logic [VALUE_W-1:0] seq_store [STORE_DEPTH];
	int unsigned        seq_len = 0;

	nearest_t    pending_nearest [$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;

	nearest_earlier_value_search #(
		.DEPTH(STORE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Runaway guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nearest_earlier_value_search regression: fail");
			$finish;
		end
	end

	function automatic logic signed_less(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [VALUE_W-1:0] value_gap(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		return signed_less(a, b) ? b - a : a - b;
	endfunction

	// Works out the result word for one accepted value, if it causes one.
	function automatic void predict_nearest(input logic [VALUE_W-1:0] value, input logic start);
		logic [VALUE_W-1:0] best_gap;
		logic [VALUE_W-1:0] best_value;
		logic [VALUE_W-1:0] gap;
		int unsigned        best_pos;
		nearest_t           res;
		if (start)
			seq_len = 0;
		// The first value of a sequence is only stored.
		if (seq_len == 0) begin
			seq_store[0] = value;
			seq_len = 1;
			return;
		end
		best_value = seq_store[0];
		best_gap   = value_gap(value, best_value);
		best_pos   = 0;
		for (int i = 1; i < seq_len; i++) begin
			gap = value_gap(value, seq_store[i]);
			// On equal distance the smaller stored value wins; equal values keep the earliest.
			if (gap < best_gap || (gap == best_gap && signed_less(seq_store[i], best_value))) begin
				best_gap   = gap;
				best_value = seq_store[i];
				best_pos   = i;
			end
		end
		if (seq_len < STORE_DEPTH) begin
			seq_store[seq_len] = value;
			seq_len++;
			res.overflow = 1'b0;
		end else begin
			res.overflow = 1'b1;
		end
		res.distance      = best_gap;
		res.nearest_index = INDEX_OUT_W'(best_pos + 1);
		pending_nearest.push_back(res);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Predicts on every accepted input word and checks every accepted result word.
	always @(posedge clk) begin
		nearest_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_nearest(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_nearest.size() == 0) begin
					report_mismatch($sformatf("result word with none expected: tdata %h",
						m_axis_tdata));
				end else begin
					want = pending_nearest.pop_front();
					if (m_axis_tdata[31:0] !== want.distance)
						report_mismatch($sformatf("distance %h, expected %h",
							m_axis_tdata[31:0], want.distance));
					if (m_axis_tdata[32 +: INDEX_OUT_W] !== want.nearest_index)
						report_mismatch($sformatf("nearest_index %0d, expected %0d",
							m_axis_tdata[32 +: INDEX_OUT_W], want.nearest_index));
					if (m_axis_tdata[47:32+INDEX_OUT_W] !== '0)
						report_mismatch($sformatf("padding bits %h not zero",
							m_axis_tdata[47:32+INDEX_OUT_W]));
					if (m_axis_tuser !== want.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							m_axis_tuser, want.overflow));
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offers one word, with random idle cycles before it, and returns once it is taken.
	task automatic send_word(input logic [VALUE_W-1:0] value, input logic start);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stops sending until every expected word has come and the row has emptied.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_nearest.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] draw_value(input spread_t spread,
			input logic [VALUE_W-1:0] centre);
		case (spread)
			SPREAD_NEAR: return centre + VALUE_W'($urandom_range(16)) - 32'd8;
			SPREAD_EDGE: begin
				case ($urandom_range(5))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return VALUE_MIN + VALUE_W'($urandom_range(3));
					3: return VALUE_MAX - VALUE_W'($urandom_range(3));
					4: return VALUE_W'($urandom_range(2)) - 32'd1;
					default: return $urandom;
				endcase
			end
			SPREAD_TINY: return VALUE_W'($urandom_range(31)) - 32'd16;
			default: return $urandom;
		endcase
	endfunction

	// Extreme values, the start flag on an empty store, lone first words and tie breaks.
	task automatic test_extremes_and_ties();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		send_word(VALUE_MAX, 1'b1);
		send_word(VALUE_MIN, 1'b0);
		send_word(32'd0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'd1, 1'b0);
		send_word(32'd0, 1'b0);
		send_word(VALUE_MAX - 32'd1, 1'b0);
		send_word(VALUE_MIN + 32'd1, 1'b0);
		// Equal distance to 10 and 20: the smaller value must win.
		send_word(32'd10, 1'b1);
		send_word(32'd20, 1'b0);
		send_word(32'd15, 1'b0);
		send_word(32'd15, 1'b0);
		send_word(32'd15, 1'b0);
		send_word(-32'sd5, 1'b0);
		// Sequences of one word give no result.
		send_word(32'd7, 1'b1);
		send_word(32'd9, 1'b1);
		send_word(VALUE_MIN, 1'b1);
		send_word(VALUE_MAX, 1'b0);
		send_word(VALUE_MAX, 1'b1);
		send_word(VALUE_MAX, 1'b0);
		send_word(VALUE_MIN, 1'b1);
		send_word(VALUE_MIN, 1'b0);
		send_word(32'h5555_5555, 1'b1);
		send_word(32'hAAAA_AAAA, 1'b0);
		drain_results();
	endtask

	// Fills the store past its depth while the receiver holds off, so the row stalls its input.
	task automatic test_store_full_backpressure();
		logic [VALUE_W-1:0] centre;
		spread_t            spread;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		centre = $urandom;
		@(negedge clk);
		hold_left = LONG_HOLD;
		@(posedge clk);
		for (int n = 0; n < STORE_DEPTH + 16; n++) begin
			spread = spread_t'($urandom_range(3));
			send_word(draw_value(spread, centre), n == 0);
		end
		drain_results();
	endtask

	// Random sequences of varied length and spread, with some broken by a stray start flag.
	task automatic test_random_sequences(input int unsigned n_words, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned        sent;
		int unsigned        seq_words;
		logic [VALUE_W-1:0] centre;
		spread_t            spread;
		logic               start;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		sent = 0;
		while (sent < n_words) begin
			case ($urandom_range(9))
				0:       seq_words = 1;
				1, 2:    seq_words = $urandom_range(41, 200);
				default: seq_words = $urandom_range(2, 40);
			endcase
			if (seq_words > n_words - sent)
				seq_words = n_words - sent;
			spread = spread_t'($urandom_range(3));
			centre = $urandom;
			for (int n = 0; n < seq_words; n++) begin
				if (n == 0)
					start = ($urandom_range(9) != 0);
				else
					start = ($urandom_range(99) < 4);
				send_word(draw_value(spread, centre), start);
			end
			sent += seq_words;
		end
		drain_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes_and_ties();
		test_store_full_backpressure();
		test_random_sequences(220, 0, 0);
		test_random_sequences(220, 48, 0);
		test_random_sequences(220, 0, 48);
		test_random_sequences(220, 36, 36);

		if (pending_nearest.size() != 0)
			report_mismatch($sformatf("%0d expected words never came", pending_nearest.size()));
		if (error_count == 0)
			$display("nearest_earlier_value_search regression: pass");
		else
			$display("nearest_earlier_value_search regression: fail");
		$finish;
	end

endmodule
